/* rtl/dhc_pkg.sv */
// Package for the DST hour corrector: types, constants and BCD helpers.
package dhc_pkg;

    typedef enum logic [1:0] {
        SEASON_WINTER  = 2'd0,
        SEASON_SUMMER  = 2'd1,
        SEASON_UNKNOWN = 2'd2
    } t_season;

    typedef enum logic {
        ACT_CORRECT = 1'b0,
        ACT_CHECK   = 1'b1
    } t_action;

    localparam logic [6:0] MonthMarch     = 7'h03;
    localparam logic [6:0] MonthOctober   = 7'h10;
    localparam logic [8:0] LastWeekBase   = 9'd23;
    localparam logic [7:0] LastSundayDate = 8'h24;
    localparam logic [7:0] SundayReg      = 8'h01;
    localparam logic [7:0] SundayDec      = 8'd1;
    localparam logic [7:0] HourSpringReg  = 8'h03;
    localparam logic [7:0] HourFallReg    = 8'h04;
    localparam logic [5:0] HourSwitch     = 6'd3;
    localparam logic [5:0] HourMax        = 6'd23;
    localparam int         TwelveHourBit  = 6;
    localparam logic [7:0] SavedWinter    = 8'd0;
    localparam logic [7:0] SavedSummer    = 8'd1;

    localparam int InDataW  = 40;
    localparam int OutDataW = 16;

    typedef struct packed {
        t_action    action;
        logic [7:0] month_reg;
        logic [7:0] weekday_reg;
        logic [7:0] date_reg;
        logic [7:0] hour_reg;
        logic [7:0] saved_flag;
    } t_item;

    typedef struct packed {
        logic       hour_write;
        logic [7:0] hour_value;
        logic       flag_write;
        t_season    season;
    } t_result;

    // (v>>4)*10 + (v&15), no check for invalid nibbles; max 165
    function automatic logic [7:0] bcd_dec(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
    endfunction

    // Binary 0..63 to BCD
    function automatic logic [7:0] dec_bcd(input logic [5:0] v);
        logic [2:0] tens;
        logic [5:0] ones;
        if (v >= 6'd60)      tens = 3'd6;
        else if (v >= 6'd50) tens = 3'd5;
        else if (v >= 6'd40) tens = 3'd4;
        else if (v >= 6'd30) tens = 3'd3;
        else if (v >= 6'd20) tens = 3'd2;
        else if (v >= 6'd10) tens = 3'd1;
        else                 tens = 3'd0;
        ones = v - ({3'd0, tens} << 3) - ({3'd0, tens} << 1);
        return {1'b0, tens, ones[3:0]};
    endfunction

endpackage

/* rtl/dhc_decide.sv */
// Season decision logic for one clock snapshot.
module dhc_decide
    import dhc_pkg::*;
(
    input  t_item   i_item,
    input  t_season i_season,
    output t_result o_result
);

    logic [6:0] month;
    logic [7:0] dow;
    logic [7:0] date;
    logic [7:0] hour_full;
    logic [5:0] hour;
    logic       last_week;
    logic       sunday;
    logic       m_lt_mar, m_gt_oct, m_mar, m_oct, m_mid;
    logic       winter_skip, summer_skip, winter_cal;
    logic [5:0] hour_inc, hour_dec;
    t_season    load_mode;

    always_comb begin
        month     = i_item.month_reg[6:0];
        dow       = bcd_dec(i_item.weekday_reg);
        date      = bcd_dec(i_item.date_reg);
        if (i_item.hour_reg[TwelveHourBit]) begin
            hour_full = bcd_dec({3'd0, i_item.hour_reg[4:0]});
        end else begin
            hour_full = bcd_dec({2'd0, i_item.hour_reg[5:0]});
        end
        hour      = hour_full[5:0];
        last_week = (LastWeekBase + {1'b0, dow}) < {1'b0, date};
        sunday    = (dow == SundayDec);

        m_lt_mar = month < MonthMarch;
        m_gt_oct = month > MonthOctober;
        m_mar    = month == MonthMarch;
        m_oct    = month == MonthOctober;
        m_mid    = (month > MonthMarch) && (month < MonthOctober);

        winter_skip = m_lt_mar || m_gt_oct
                   || (m_mar && (!last_week || (sunday && hour < HourSwitch)))
                   || (m_oct && last_week && (!sunday || hour >= HourSwitch));
        summer_skip = m_mid
                   || (m_oct && (!last_week || (sunday && hour <= HourSwitch)))
                   || (m_mar && last_week && (!sunday || hour > HourSwitch));
        winter_cal  = m_lt_mar || m_gt_oct || (m_mar && !last_week)
                   || (m_oct && last_week);

        hour_inc = (hour < HourMax) ? hour + 6'd1 : 6'd0;
        hour_dec = (hour > 6'd0) ? hour - 6'd1 : HourMax;

        if (i_item.saved_flag == SavedWinter) begin
            load_mode = SEASON_WINTER;
        end else if (i_item.saved_flag == SavedSummer) begin
            load_mode = SEASON_SUMMER;
        end else begin
            load_mode = SEASON_UNKNOWN;
        end

        o_result.hour_write = 1'b0;
        o_result.hour_value = 8'd0;
        o_result.flag_write = 1'b0;
        o_result.season     = i_season;

        case (i_item.action)
            ACT_CORRECT: begin
                o_result.season = load_mode;
                case (load_mode)
                    SEASON_WINTER: begin
                        if (!winter_skip) begin
                            o_result.hour_write = 1'b1;
                            o_result.flag_write = 1'b1;
                            o_result.hour_value = dec_bcd(hour_inc);
                            o_result.season     = SEASON_SUMMER;
                        end
                    end
                    SEASON_SUMMER: begin
                        if (!summer_skip) begin
                            o_result.hour_write = 1'b1;
                            o_result.flag_write = 1'b1;
                            o_result.hour_value = dec_bcd(hour_dec);
                            o_result.season     = SEASON_WINTER;
                        end
                    end
                    default: begin
                        o_result.hour_write = 1'b1;
                        o_result.flag_write = 1'b1;
                        o_result.hour_value = dec_bcd(hour);
                        o_result.season     = winter_cal ? SEASON_WINTER : SEASON_SUMMER;
                    end
                endcase
            end
            ACT_CHECK: begin
                // switch exactly on the hour, only on the last Sunday
                if (i_item.weekday_reg == SundayReg && i_item.date_reg > LastSundayDate) begin
                    if (i_season == SEASON_WINTER) begin
                        if (m_mar && i_item.hour_reg == HourSpringReg) begin
                            o_result.hour_write = 1'b1;
                            o_result.flag_write = 1'b1;
                            o_result.hour_value = HourFallReg;
                            o_result.season     = SEASON_SUMMER;
                        end
                    end else if (m_oct && i_item.hour_reg == HourFallReg) begin
                        o_result.hour_write = 1'b1;
                        o_result.flag_write = 1'b1;
                        o_result.hour_value = HourSpringReg;
                        o_result.season     = SEASON_WINTER;
                    end
                end
            end
            default: begin
                o_result.season = i_season;
            end
        endcase
    end

endmodule

/* rtl/dst_hour_corrector_core.sv */
// Top level of the DST hour corrector: input register, decision, result register.
// Applies the European summer-time rule to one clock snapshot per transaction.
// A transaction is registered on input, decided against the stored season mode
// as it is loaded into the result register, and held there until taken, so one
// item per cycle is sustained while the sink is ready.
// The season mode resets to unknown and is updated as each result is loaded,
// so consecutive items see each other's season changes in order.
module dst_hour_corrector_core
    import dhc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // month_reg[7:0], weekday_reg[15:8], date_reg[23:16], hour_reg[31:24], saved_flag[39:32]
    input  logic [InDataW-1:0]  i_s_tdata,
    // action[0]
    input  logic                i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // hour_write[0], hour_value[8:1], flag_write[9], season[11:10], zero[15:12]
    output logic [OutDataW-1:0] o_m_tdata
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_season r_season;
    t_result n_out;
    logic    advance;
    logic    load_out;

    assign advance    = !r_out_valid || i_m_tready;
    assign load_out   = advance && r_in_valid;
    assign o_s_tready = advance || !r_in_valid;

    dhc_decide u_decide (
        .i_item   (r_in),
        .i_season (r_season),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_season    <= SEASON_UNKNOWN;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (load_out) begin
                r_season <= n_out.season;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.action      <= t_action'(i_s_tuser);
            r_in.month_reg   <= i_s_tdata[7:0];
            r_in.weekday_reg <= i_s_tdata[15:8];
            r_in.date_reg    <= i_s_tdata[23:16];
            r_in.hour_reg    <= i_s_tdata[31:24];
            r_in.saved_flag  <= i_s_tdata[39:32];
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out.season, r_out.flag_write, r_out.hour_value,
                         r_out.hour_write};

`ifndef SYNTHESIS
    a_writes_paired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.hour_write == r_out.flag_write))
        else $error("hour and flag writes differ");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.hour_write) |-> (r_out.hour_value == 8'd0))
        else $error("hour value set without write");

    a_season_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(load_out) |-> (r_out.season == r_season))
        else $error("reported season differs from stored mode");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |-> !o_s_tready)
        else $error("input taken while pending item blocked");
`endif

endmodule

/* bench/dst_hour_corrector_core_test.sv */
// Testbench for dst_hour_corrector_core: directed and random clock snapshots.
`timescale 1ns / 100ps

module dst_hour_corrector_core_test
    import dhc_pkg::*;
;

    localparam int CycleLimit = 80000;
    localparam int LongHold   = 300;
    localparam int TailCycles = 8;
    localparam int MaxPrinted = 100;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    // month_reg[7:0], weekday_reg[15:8], date_reg[23:16], hour_reg[31:24], saved_flag[39:32]
    logic [InDataW-1:0]  i_s_tdata = '0;
    // action[0]
    logic                i_s_tuser = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    // hour_write[0], hour_value[8:1], flag_write[9], season[11:10], zero[15:12]
    logic [OutDataW-1:0] o_m_tdata;

    t_result     pending_results[$];
    t_season     season_now = SEASON_UNKNOWN;
    int          sender_idle_pct = 0;
    int          sink_stall_pct = 0;
    logic        hold_req = 1'b0;
    int          hold_left = 0;
    int          error_count = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          check_switches = 0;
    int unsigned cycle_count = 0;

    dst_hour_corrector_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int bcd_value(input logic [7:0] v);
        return int'(v[7:4]) * 10 + int'(v[3:0]);
    endfunction

    function automatic logic [7:0] to_bcd(input int v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    // Applies one snapshot to the tracked season and returns the expected hour/flag writes.
    function automatic t_result compute_correction(input t_item it);
        t_result    r;
        logic [6:0] mon;
        int         dow;
        int         day;
        int         hr;
        bit         last_wk;
        bit         fix;
        r = '0;
        mon = it.month_reg[6:0];
        dow = bcd_value(it.weekday_reg);
        day = bcd_value(it.date_reg);
        hr = it.hour_reg[TwelveHourBit] ? bcd_value({3'b000, it.hour_reg[4:0]})
                                        : bcd_value({2'b00, it.hour_reg[5:0]});
        last_wk = (int'(LastWeekBase) + dow) < day;
        if (it.action == ACT_CORRECT) begin
            fix = 1'b1;
            season_now = (it.saved_flag == SavedWinter) ? SEASON_WINTER :
                         (it.saved_flag == SavedSummer) ? SEASON_SUMMER : SEASON_UNKNOWN;
            case (season_now)
                SEASON_WINTER: begin
                    if (mon < MonthMarch || mon > MonthOctober) begin
                        fix = 1'b0;
                    end else if (mon == MonthMarch) begin
                        if (!last_wk || (dow == 1 && hr < HourSwitch)) fix = 1'b0;
                    end else if (mon == MonthOctober) begin
                        if (last_wk && (dow != 1 || hr >= HourSwitch)) fix = 1'b0;
                    end
                    if (fix) begin
                        hr = (hr < HourMax) ? hr + 1 : 0;
                        season_now = SEASON_SUMMER;
                    end
                end
                SEASON_SUMMER: begin
                    if (mon > MonthMarch && mon < MonthOctober) begin
                        fix = 1'b0;
                    end else if (mon == MonthOctober) begin
                        if (!last_wk || (dow == 1 && hr <= HourSwitch)) fix = 1'b0;
                    end else if (mon == MonthMarch) begin
                        if (last_wk && (dow != 1 || hr > HourSwitch)) fix = 1'b0;
                    end
                    if (fix) begin
                        hr = (hr > 0) ? hr - 1 : int'(HourMax);
                        season_now = SEASON_WINTER;
                    end
                end
                default: begin
                    // unknown: classify from month and date, hour kept
                    if (mon < MonthMarch || mon > MonthOctober ||
                        (mon == MonthMarch && !last_wk) ||
                        (mon == MonthOctober && last_wk)) begin
                        season_now = SEASON_WINTER;
                    end else begin
                        season_now = SEASON_SUMMER;
                    end
                end
            endcase
            if (fix) begin
                r.hour_write = 1'b1;
                r.hour_value = to_bcd(hr);
                r.flag_write = 1'b1;
            end
        end else if (dow == 1 && it.date_reg > LastSundayDate) begin
            if (season_now == SEASON_WINTER) begin
                if (mon == MonthMarch && it.hour_reg == HourSpringReg) begin
                    r.hour_write = 1'b1;
                    r.hour_value = 8'h04;
                    r.flag_write = 1'b1;
                    season_now = SEASON_SUMMER;
                end
            end else if (mon == MonthOctober && it.hour_reg == HourFallReg) begin
                r.hour_write = 1'b1;
                r.hour_value = 8'h03;
                r.flag_write = 1'b1;
                season_now = SEASON_WINTER;
            end
        end
        r.season = season_now;
        return r;
    endfunction

    function automatic t_item make_snapshot(input t_action act, input logic [7:0] mon,
                                            input logic [7:0] wd, input logic [7:0] dt,
                                            input logic [7:0] hr, input logic [7:0] saved);
        t_item it;
        it.action = act;
        it.month_reg = mon;
        it.weekday_reg = wd;
        it.date_reg = dt;
        it.hour_reg = hr;
        it.saved_flag = saved;
        return it;
    endfunction

    // Mostly plausible calendar readings, weighted toward the switch weekends.
    function automatic t_item random_snapshot();
        t_item      it;
        int         kind;
        int         mon;
        int         day;
        int         hr;
        int         pick;
        logic [7:0] hb;
        kind = $urandom_range(99);
        it.action = ($urandom_range(99) < 30) ? ACT_CORRECT : ACT_CHECK;
        if (kind < 12) begin
            it.month_reg = 8'($urandom_range(255));
            it.weekday_reg = 8'($urandom_range(255));
            it.date_reg = 8'($urandom_range(255));
            it.hour_reg = 8'($urandom_range(255));
            it.saved_flag = 8'($urandom_range(255));
            return it;
        end
        if (kind < 60) begin
            mon = $urandom_range(1) ? 3 : 10;
            day = $urandom_range(22, 31);
            hr = $urandom_range(1, 5);
            it.weekday_reg = $urandom_range(2) ? 8'h01 : to_bcd($urandom_range(1, 7));
        end else begin
            mon = $urandom_range(1, 12);
            day = $urandom_range(1, 31);
            hr = $urandom_range(0, 23);
            it.weekday_reg = to_bcd($urandom_range(1, 7));
        end
        it.month_reg = to_bcd(mon);
        it.month_reg[7] = 1'($urandom_range(1));
        it.date_reg = to_bcd(day);
        if ($urandom_range(99) < 15) begin
            hb = to_bcd($urandom_range(1, 12));
            it.hour_reg = {2'b01, 1'($urandom_range(1)), hb[4:0]};
        end else begin
            it.hour_reg = to_bcd(hr);
        end
        pick = $urandom_range(9);
        if (pick < 4)      it.saved_flag = SavedWinter;
        else if (pick < 8) it.saved_flag = SavedSummer;
        else               it.saved_flag = 8'($urandom_range(255));
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MaxPrinted)
            $display("%0t: mismatch on %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Called and returns at a rising edge; valid stays up between back-to-back items.
    task automatic send_snapshot(input t_item it);
        t_result want;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {it.saved_flag, it.hour_reg, it.date_reg, it.weekday_reg, it.month_reg};
        i_s_tuser  <= it.action;
        do @(posedge i_clk); while (!o_s_tready);
        want = compute_correction(it);
        pending_results.push_back(want);
        items_sent++;
        if (it.action == ACT_CHECK && want.hour_write) check_switches++;
    endtask

    task automatic wait_for_results();
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Sink side: random stalls, plus a long hold on request.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = LongHold;
            hold_req <= 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", int'(o_m_tdata), 0);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_m_tdata[0] !== want.hour_write)
                    report_mismatch("hour_write", o_m_tdata[0], want.hour_write);
                if (o_m_tdata[8:1] !== want.hour_value)
                    report_mismatch("hour_value", o_m_tdata[8:1], want.hour_value);
                if (o_m_tdata[9] !== want.flag_write)
                    report_mismatch("flag_write", o_m_tdata[9], want.flag_write);
                if (o_m_tdata[11:10] !== want.season)
                    report_mismatch("season", o_m_tdata[11:10], want.season);
                if (o_m_tdata[15:12] !== 4'd0)
                    report_mismatch("pad bits", o_m_tdata[15:12], 0);
            end
        end
    end

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("dst_hour_corrector_core_test: done, errors");
        $finish;
    end

    // Season is unknown only out of reset, so this runs first.
    task automatic test_check_from_unknown();
        send_snapshot(make_snapshot(ACT_CHECK, 8'h03, 8'h01, 8'h31, 8'h03, 8'h00));
        send_snapshot(make_snapshot(ACT_CHECK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_snapshot(make_snapshot(ACT_CHECK, 8'h10, 8'h01, 8'h25, 8'h04, 8'h01));
    endtask

    task automatic test_startup_correction();
        send_snapshot(make_snapshot(ACT_CORRECT, 8'h01, 8'h03, 8'h15, 8'h10, 8'h00));
        // hour wraps 23 -> 0 going to summer, 0 -> 23 going to winter
        send_snapshot(make_snapshot(ACT_CORRECT, 8'h07, 8'h04, 8'h12, 8'h23, 8'h00));
        send_snapshot(make_snapshot(ACT_CORRECT, 8'h12, 8'h02, 8'h20, 8'h00, 8'h01));
        send_snapshot(make_snapshot(ACT_CORRECT, 8'h06, 8'h05, 8'h09, 8'h14, 8'h01));
        send_snapshot(make_snapshot(ACT_CORRECT, 8'h03, 8'h06, 8'h10, 8'h08, 8'h02));
        send_snapshot(make_snapshot(ACT_CORRECT, 8'h10, 8'h05, 8'h30, 8'h11, 8'hFF));
        // invalid BCD month sits between March and October
        send_snapshot(make_snapshot(ACT_CORRECT, 8'h0A, 8'h03, 8'h05, 8'h09, 8'h80));
        send_snapshot(make_snapshot(ACT_CORRECT, 8'h03, 8'h01, 8'h31, 8'h02, 8'h00));
        send_snapshot(make_snapshot(ACT_CORRECT, 8'h03, 8'h01, 8'h31, 8'h03, 8'h00));
        send_snapshot(make_snapshot(ACT_CORRECT, 8'h10, 8'h01, 8'h27, 8'h03, 8'h01));
        send_snapshot(make_snapshot(ACT_CORRECT, 8'h10, 8'h01, 8'h27, 8'h04, 8'h01));
        // 12-hour mode, PM 12
        send_snapshot(make_snapshot(ACT_CORRECT, 8'h08, 8'h02, 8'h14, 8'h72, 8'h00));
        // century bit set on month
        send_snapshot(make_snapshot(ACT_CORRECT, 8'h83, 8'h04, 8'h02, 8'h21, 8'h02));
        send_snapshot(make_snapshot(ACT_CORRECT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_snapshot(make_snapshot(ACT_CORRECT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    task automatic test_check_switching();
        send_snapshot(make_snapshot(ACT_CORRECT, 8'h01, 8'h03, 8'h15, 8'h10, 8'h00));
        send_snapshot(make_snapshot(ACT_CHECK, 8'h03, 8'h01, 8'h24, 8'h03, 8'hA5));
        send_snapshot(make_snapshot(ACT_CHECK, 8'h03, 8'h02, 8'h25, 8'h03, 8'hA5));
        send_snapshot(make_snapshot(ACT_CHECK, 8'h83, 8'h01, 8'h26, 8'h03, 8'hA5));
        send_snapshot(make_snapshot(ACT_CHECK, 8'h03, 8'h01, 8'h26, 8'h03, 8'h5A));
        send_snapshot(make_snapshot(ACT_CHECK, 8'h10, 8'h01, 8'h31, 8'h04, 8'h5A));
        send_snapshot(make_snapshot(ACT_CHECK, 8'h10, 8'h01, 8'h31, 8'h04, 8'h00));
        send_snapshot(make_snapshot(ACT_CHECK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    task automatic test_random_under_idling();
        int send_pct[4];
        int sink_pct[4];
        send_pct = '{0, 59, 0, 24};
        sink_pct = '{0, 0, 59, 24};
        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = send_pct[p];
            sink_stall_pct = sink_pct[p];
            repeat (140) send_snapshot(random_snapshot());
        end
    endtask

    // Sink holds off while the source keeps offering, so the input stalls.
    task automatic test_output_hold();
        sender_idle_pct = 0;
        sink_stall_pct = 0;
        hold_req <= 1'b1;
        repeat (40) send_snapshot(random_snapshot());
    endtask

    task automatic test_pause_for_drain();
        sender_idle_pct = 24;
        sink_stall_pct = 24;
        repeat (15) send_snapshot(random_snapshot());
        i_s_tvalid <= 1'b0;
        wait_for_results();
        repeat (15) send_snapshot(random_snapshot());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_check_from_unknown();
        test_startup_correction();
        test_check_switching();
        test_random_under_idling();
        test_output_hold();
        test_pause_for_drain();

        i_s_tvalid <= 1'b0;
        wait_for_results();
        repeat (TailCycles) @(posedge i_clk);

        $display("covered %0d snapshots, %0d results compared, %0d switches by periodic check",
                 items_sent, results_checked, check_switches);
        $display("idling: none, source, sink, both; one long sink hold and one full drain pause");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("dst_hour_corrector_core_test: done, clean");
        end else begin
            $display("dst_hour_corrector_core_test: done, errors");
        end
        $finish;
    end

endmodule
